// ===== sv/sequential_list_engine_unit_defines.svh =====
// Assertion macros shared by the checker of the sequential list engine.
// Depends on nothing; the including scope must provide clk and rst_n.
`ifndef SEQUENTIAL_LIST_ENGINE_UNIT_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sle_pkg.sv =====
// Package for the sequential list engine: operation codes, cell control and
// group result types. Depends on nothing.
package sle_pkg;

    // Operation codes carried in the kind field.
    localparam logic [2:0] KIND_INSERT = 3'd0;
    localparam logic [2:0] KIND_DELETE = 3'd1;
    localparam logic [2:0] KIND_READ   = 3'd2;
    localparam logic [2:0] KIND_FIND   = 3'd3;
    localparam logic [2:0] KIND_CLEAR  = 3'd4;

    // Width of positions and lengths inside the cell row; covers up to 2047 cells.
    localparam int IDX_W = 11;

    // Cells are reduced in groups of this size.
    localparam int GROUP_SIZE = 8;
    localparam int GRP_W      = 3;

    localparam int DATA_W = 32;

    // Control broadcast to every cell for one beat.
    typedef struct packed {
        logic              ins;
        logic              del;
        logic              clr;
        logic [IDX_W-1:0]  p;
        logic [IDX_W-1:0]  len;
        logic [DATA_W-1:0] value;
    } cell_ctrl_t;

    // Registered summary of one group of cells.
    typedef struct packed {
        logic [DATA_W-1:0] sel_value;
        logic              hit;
        logic [GRP_W-1:0]  first;
    } group_res_t;

endpackage

// ===== sv/sle_cell.sv =====
// One list cell: holds one element, shifts to and from its neighbors and
// compares itself with the broadcast position and search value. Uses sle_pkg.
module sle_cell #(
    parameter int INDEX = 0
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  sle_pkg::cell_ctrl_t      ctrl,
    input  logic [sle_pkg::DATA_W-1:0] left_data,
    input  logic [sle_pkg::DATA_W-1:0] right_data,
    output logic [sle_pkg::DATA_W-1:0] data,
    output logic                     sel,
    output logic                     match
);
    import sle_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(INDEX);
    localparam logic [IDX_W-1:0] NEXT_IDX = IDX_W'(INDEX + 1);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // Insert moves entries above the position up by one; delete pulls the
    // entries from the position to the second-to-last one down by one.
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.clr)
        begin
            data_next = '0;
        end
        else if (ctrl.ins)
        begin
            if (MY_IDX > ctrl.p)
            begin
                data_next = left_data;
            end
            else if (MY_IDX == ctrl.p)
            begin
                data_next = ctrl.value;
            end
        end
        else if (ctrl.del)
        begin
            if ((MY_IDX >= ctrl.p) && (NEXT_IDX < ctrl.len))
            begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    // Flags for the group reduction, taken from the contents before the update.
    assign data  = data_reg;
    assign sel   = (MY_IDX == ctrl.p);
    assign match = (data_reg == ctrl.value) && (MY_IDX < ctrl.len);

endmodule

// ===== sv/sle_group.sv =====
// Group reducer: summarizes eight cells into the selected value and the
// first matching local index, registered on each accepted beat. Uses sle_pkg.
module sle_group (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  logic [sle_pkg::DATA_W-1:0] data [sle_pkg::GROUP_SIZE],
    input  logic [sle_pkg::GROUP_SIZE-1:0] sel,
    input  logic [sle_pkg::GROUP_SIZE-1:0] match,
    output sle_pkg::group_res_t      res
);
    import sle_pkg::*;

    group_res_t res_reg;
    group_res_t res_next;

    // At most one cell is selected, so an OR of the gated values picks it.
    // The lowest matching cell wins the priority search.
    always_comb
    begin
        res_next.sel_value = '0;
        res_next.hit       = |match;
        res_next.first     = '0;
        for (int k = 0; k < GROUP_SIZE; k++)
        begin
            if (sel[k])
            begin
                res_next.sel_value = res_next.sel_value | data[k];
            end
        end
        for (int k = GROUP_SIZE - 1; k >= 0; k--)
        begin
            if (match[k])
            begin
                res_next.first = GRP_W'(k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== sv/sequential_list_engine_unit.sv =====
// Top level of the sequential list engine: a row of list cells, group
// reducers and the result stage. Uses sle_pkg, sle_cell and sle_group.
//
//  channel | handshake            | fields
//  --------+----------------------+----------------------------------
//  request | req_valid, req_stall | kind, position, value
//  result  | rsp_valid, rsp_stall | ok, value_out, found_index, count
//
// For every request, the cells shift and the groups summarize at the
// accepting edge, and the group summaries merge into the result register
// at the next edge. One request is in flight at a time, so the request side
// stalls until the result register is free. Reset clears the list at once.
// A stalled result holds the request side as well.
module sequential_list_engine_unit #(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [2:0]         kind,
    input  logic [6:0]         position,
    input  logic signed [31:0] value,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic               ok,
    output logic signed [31:0] value_out,
    output logic [5:0]         found_index,
    output logic [6:0]         count
);
    import sle_pkg::*;

    localparam int LW  = $clog2(CAPACITY + 1);
    localparam int GN  = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD = GN * GROUP_SIZE;

    // Control state.
    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;
    logic          pend_reg;
    logic          pend_next;
    logic          rsp_valid_reg;
    logic          rsp_valid_next;

    // Request held between the two steps.
    logic [2:0]    kind_reg;
    logic          okpre_reg;
    logic          okpre_next;
    logic [6:0]    cnt_reg;

    // Result register.
    logic              ok_reg;
    logic              ok_next;
    logic [DATA_W-1:0] vout_reg;
    logic [DATA_W-1:0] vout_next;
    logic [5:0]        fidx_reg;
    logic [5:0]        fidx_next;
    logic [6:0]        count_reg;

    logic              accept;
    logic              move;
    logic [IDX_W-1:0]  pos_x;
    logic [IDX_W-1:0]  len_x;
    logic              ins_ok;
    logic              acc_ok;
    cell_ctrl_t        ctrl;

    logic [DATA_W-1:0]     cell_data [CAPACITY];
    logic [CAPACITY-1:0]   cell_sel;
    logic [CAPACITY-1:0]   cell_match;
    logic [DATA_W-1:0]     pad_data  [PAD];
    logic [PAD-1:0]        pad_sel;
    logic [PAD-1:0]        pad_match;
    group_res_t            grp_res   [GN];

    logic [DATA_W-1:0] any_value;
    logic              any_hit;
    logic [IDX_W-1:0]  first_idx;

    // Request decode against the current length.
    assign accept = req_valid && !req_stall;
    assign pos_x  = IDX_W'(position);
    assign len_x  = IDX_W'(len_reg);
    assign ins_ok = (pos_x != '0) && (pos_x <= len_x + IDX_W'(1))
                    && (len_x < IDX_W'(CAPACITY));
    assign acc_ok = (pos_x != '0) && (pos_x <= len_x);

    assign ctrl.ins   = accept && (kind == KIND_INSERT) && ins_ok;
    assign ctrl.del   = accept && (kind == KIND_DELETE) && acc_ok;
    assign ctrl.clr   = accept && (kind == KIND_CLEAR);
    assign ctrl.p     = pos_x - IDX_W'(1);
    assign ctrl.len   = len_x;
    assign ctrl.value = value;

    // Length update and early success flag.
    always_comb
    begin
        len_next = len_reg;
        if (ctrl.clr)
        begin
            len_next = '0;
        end
        else if (ctrl.ins)
        begin
            len_next = len_reg + LW'(1);
        end
        else if (ctrl.del)
        begin
            len_next = len_reg - LW'(1);
        end
    end

    always_comb
    begin
        case (kind)
            KIND_INSERT: okpre_next = ins_ok;
            KIND_DELETE: okpre_next = acc_ok;
            KIND_READ:   okpre_next = acc_ok;
            KIND_CLEAR:  okpre_next = 1'b1;
            default:     okpre_next = 1'b0;
        endcase
    end

    // The row of cells, each wired to both neighbors.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;
        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end
        sle_cell #(.INDEX(i)) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .sel        (cell_sel[i]),
            .match      (cell_match[i])
        );
    end

    // Pad the row to whole groups.
    for (genvar k = 0; k < PAD; k++)
    begin : g_pad
        if (k < CAPACITY)
        begin : g_real
            assign pad_data[k]  = cell_data[k];
            assign pad_sel[k]   = cell_sel[k];
            assign pad_match[k] = cell_match[k];
        end
        else
        begin : g_fill
            assign pad_data[k]  = '0;
            assign pad_sel[k]   = 1'b0;
            assign pad_match[k] = 1'b0;
        end
    end

    for (genvar g = 0; g < GN; g++)
    begin : g_group
        sle_group u_group (
            .clk   (clk),
            .rst_n (rst_n),
            .load  (accept),
            .data  (pad_data[g*GROUP_SIZE +: GROUP_SIZE]),
            .sel   (pad_sel[g*GROUP_SIZE +: GROUP_SIZE]),
            .match (pad_match[g*GROUP_SIZE +: GROUP_SIZE]),
            .res   (grp_res[g])
        );
    end

    // Merge the group summaries; the lowest matching group wins.
    always_comb
    begin
        any_value = '0;
        any_hit   = 1'b0;
        first_idx = '0;
        for (int g = 0; g < GN; g++)
        begin
            any_value = any_value | grp_res[g].sel_value;
        end
        for (int g = GN - 1; g >= 0; g--)
        begin
            if (grp_res[g].hit)
            begin
                any_hit   = 1'b1;
                first_idx = (IDX_W'(g) << GRP_W) | IDX_W'(grp_res[g].first);
            end
        end
    end

    // Final result fields.
    always_comb
    begin
        ok_next   = okpre_reg;
        vout_next = '0;
        fidx_next = '0;
        if (kind_reg == KIND_FIND)
        begin
            ok_next = any_hit;
            if (any_hit)
            begin
                fidx_next = first_idx[5:0];
            end
        end
        else if ((kind_reg inside {KIND_DELETE, KIND_READ}) && okpre_reg)
        begin
            vout_next = any_value;
        end
    end

    // Handshake: one request in flight, result register in front of the port.
    assign move      = pend_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = pend_reg || (rsp_valid_reg && rsp_stall);

    always_comb
    begin
        pend_next = pend_reg;
        if (accept)
        begin
            pend_next = 1'b1;
        end
        else if (move)
        begin
            pend_next = 1'b0;
        end
        rsp_valid_next = rsp_valid_reg;
        if (move)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind;
            okpre_reg <= okpre_next;
            cnt_reg   <= 7'(len_next);
        end
        if (move)
        begin
            ok_reg    <= ok_next;
            vout_reg  <= vout_next;
            fidx_reg  <= fidx_next;
            count_reg <= cnt_reg;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign ok          = ok_reg;
    assign value_out   = vout_reg;
    assign found_index = fidx_reg;
    assign count       = count_reg;

endmodule

// ===== sv/sle_checker.sv =====
// Port-level checker for the sequential list engine and its bind.
// Depends on sequential_list_engine_unit_defines.svh.
`include "sequential_list_engine_unit_defines.svh"

module sle_checker #(
    parameter int CAPACITY = 64
) (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input logic               ok,
    input logic signed [31:0] value_out,
    input logic [5:0]         found_index,
    input logic [6:0]         count
);

    // A stalled result beat stays valid and keeps its value and count.
    `SLE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(value_out) && $stable(count), "result beat changed while stalled")

    // Only one request is in flight, so an accepted beat stalls the next one.
    `SLE_ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall, "request accepted while another is in flight")

    // A failed operation reports no value and no index.
    `SLE_ASSERT_SAME(a_fail_zero, rsp_valid && !ok, value_out == 32'sd0 && found_index == 6'd0, "failed result carries data")

    // The list never grows past its capacity.
    `SLE_ASSERT_SAME(a_count_cap, rsp_valid, (CAPACITY > 127) || (int'(count) <= CAPACITY), "count above capacity")

endmodule

bind sequential_list_engine_unit sle_checker #(.CAPACITY(CAPACITY)) u_sle_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .ok          (ok),
    .value_out   (value_out),
    .found_index (found_index),
    .count       (count)
);

// ===== tb/sv/sequential_list_engine_unit_test.sv =====
// Self-checking testbench for sequential_list_engine_unit: random and directed list operations
// are predicted by a behavioral list and checked beat by beat.
// Depends on sle_pkg and the sequential_list_engine_unit RTL.
module sequential_list_engine_unit_test;
    import sle_pkg::*;

    localparam int LIST_DEPTH  = 64;
    localparam int TOTAL_ITEMS = 950;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [2:0]         kind;
        logic [6:0]         position;
        logic signed [31:0] value;
    } list_op_t;

    typedef struct {
        logic               ok;
        logic signed [31:0] value_out;
        logic [5:0]         found_index;
        logic [6:0]         count;
    } list_result_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               req_valid   = 1'b0;
    logic               req_stall;
    logic [2:0]         kind        = '0;
    logic [6:0]         position    = '0;
    logic signed [31:0] value       = '0;
    logic               rsp_valid;
    logic               rsp_stall   = 1'b0;
    logic               ok;
    logic signed [31:0] value_out;
    logic [5:0]         found_index;
    logic [6:0]         count;
    logic               long_hold   = 1'b0;

    // Beats waiting to be offered and results waiting to arrive.
    list_op_t           pending_ops[$];
    list_result_t       pending_results[$];

    // Behavioral copy of the list, advanced as each request beat is accepted.
    logic signed [31:0] model_cells [LIST_DEPTH];
    int                 model_len;

    // Length as the stimulus generator sees it, and values already inserted.
    int                 stim_len;
    logic signed [31:0] value_pool[$];

    int n_items;
    int n_accepted;
    int n_results;
    int n_fail;
    int cycle_count;
    int send_gap;
    int send_calm;
    int recv_left;
    int recv_calm;

    sequential_list_engine_unit #(
        .CAPACITY(LIST_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .kind(kind),
        .position(position),
        .value(value),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .ok(ok),
        .value_out(value_out),
        .found_index(found_index),
        .count(count)
    );

    always #6 clk = ~clk;

    // Applies one operation to the behavioral list and returns its result.
    function automatic list_result_t apply_list_op(input list_op_t op);
        list_result_t r;
        int p;
        r.ok = 1'b0;
        r.value_out = '0;
        r.found_index = '0;
        p = op.position;
        case (op.kind)
            KIND_INSERT:
            begin
                if (p >= 1 && p <= model_len + 1 && model_len < LIST_DEPTH)
                begin
                    for (int j = model_len; j >= p; j--)
                        model_cells[j] = model_cells[j-1];
                    model_cells[p-1] = op.value;
                    model_len++;
                    r.ok = 1'b1;
                end
            end
            KIND_DELETE:
            begin
                if (p >= 1 && p <= model_len)
                begin
                    r.value_out = model_cells[p-1];
                    for (int j = p; j < model_len; j++)
                        model_cells[j-1] = model_cells[j];
                    model_len--;
                    r.ok = 1'b1;
                end
            end
            KIND_READ:
            begin
                if (p >= 1 && p <= model_len)
                begin
                    r.value_out = model_cells[p-1];
                    r.ok = 1'b1;
                end
            end
            KIND_FIND:
            begin
                // The first match wins, so the scan stops once one is seen.
                for (int j = 0; j < model_len && !r.ok; j++)
                begin
                    if (model_cells[j] == op.value)
                    begin
                        r.ok = 1'b1;
                        r.found_index = j[5:0];
                    end
                end
            end
            KIND_CLEAR:
            begin
                for (int j = 0; j < LIST_DEPTH; j++)
                    model_cells[j] = '0;
                model_len = 0;
                r.ok = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.count = model_len[6:0];
        return r;
    endfunction

    // Idle length for either side: mostly none, some short, a few long, and
    // now and then a calm stretch with no idling at all.
    function automatic int pick_idle(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Position in 1..hi, leaning on both ends of the range.
    function automatic int pick_pos(input int hi);
        int r;
        if (hi < 1)
            return 1;
        r = $urandom_range(0, 99);
        if (r < 20)
            return 1;
        if (r < 40)
            return hi;
        return $urandom_range(1, hi);
    endfunction

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom;
        if (r < 70)
            return int'($urandom_range(0, 15)) - 8;
        if (r < 80)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'sh7fff_ffff;
                1:       return 32'sh8000_0000;
                2:       return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        if (value_pool.size() > 0)
            return value_pool[$urandom_range(0, value_pool.size() - 1)];
        return $urandom;
    endfunction

    function automatic logic signed [31:0] pick_search();
        if (value_pool.size() > 0 && $urandom_range(0, 99) < 60)
            return value_pool[$urandom_range(0, value_pool.size() - 1)];
        return pick_value();
    endfunction

    // Queues one request beat and tracks the list length it leads to.
    task automatic add_op(input logic [2:0] k, input int p, input logic signed [31:0] v);
        list_op_t op;
        op.kind = k;
        op.position = p[6:0];
        op.value = v;
        pending_ops.push_back(op);
        case (k)
            KIND_INSERT:
            begin
                if (op.position >= 1 && op.position <= stim_len + 1 && stim_len < LIST_DEPTH)
                begin
                    stim_len++;
                    value_pool.push_back(v);
                    if (value_pool.size() > 32)
                        value_pool.delete(0);
                end
            end
            KIND_DELETE:
            begin
                if (op.position >= 1 && op.position <= stim_len)
                    stim_len--;
            end
            KIND_CLEAR:
                stim_len = 0;
            default:
            begin
            end
        endcase
    endtask

    // Request driver: offers queued beats, holds a stalled beat, idles at random.
    always @(posedge clk or negedge rst_n)
    begin
        list_op_t op;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            kind      <= '0;
            position  <= '0;
            value     <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                op.kind = kind;
                op.position = position;
                op.value = value;
                pending_results.push_back(apply_list_op(op));
                n_accepted++;
                send_gap = pick_idle(send_calm);
            end
            if (!req_valid || !req_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_valid <= 1'b0;
                end
                else if (pending_ops.size() > 0)
                begin
                    op = pending_ops.pop_front();
                    req_valid <= 1'b1;
                    kind      <= op.kind;
                    position  <= op.position;
                    value     <= op.value;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each accepted beat and drives the stall.
    always @(posedge clk or negedge rst_n)
    begin
        list_result_t exp_r;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                n_results++;
                if (pending_results.size() == 0)
                begin
                    $error("result beat arrived with no request outstanding");
                    n_fail++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (ok !== exp_r.ok)
                    begin
                        $error("ok: expected %0d, actual %0d", exp_r.ok, ok);
                        n_fail++;
                    end
                    if (value_out !== exp_r.value_out)
                    begin
                        $error("value_out: expected %0d, actual %0d", exp_r.value_out, value_out);
                        n_fail++;
                    end
                    if (found_index !== exp_r.found_index)
                    begin
                        $error("found_index: expected %0d, actual %0d",
                               exp_r.found_index, found_index);
                        n_fail++;
                    end
                    if (count !== exp_r.count)
                    begin
                        $error("count: expected %0d, actual %0d", exp_r.count, count);
                        n_fail++;
                    end
                end
            end
            if (long_hold)
            begin
                rsp_stall <= 1'b1;
            end
            else if (recv_left > 0)
            begin
                recv_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                recv_left = pick_idle(recv_calm);
                rsp_stall <= (recv_left > 0);
            end
        end
    end

    // Long receiver hold-off while requests keep coming, so the input side backs up.
    initial
    begin
        wait (n_accepted >= 150);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold <= 1'b0;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int mode;
        int phase_len;
        int r;
        int first_phase;

        for (int j = 0; j < LIST_DEPTH; j++)
            model_cells[j] = '0;
        model_len = 0;
        stim_len = 0;

        // Directed beats: empty list, bad positions, both ends, unused kinds, clear.
        add_op(KIND_READ,   1,   32'sd0);
        add_op(KIND_DELETE, 1,   32'sd0);
        add_op(KIND_FIND,   0,   32'sd0);
        add_op(KIND_INSERT, 0,   32'sd5);
        add_op(KIND_INSERT, 2,   32'sd5);
        add_op(KIND_INSERT, 1,   32'sh7fff_ffff);
        add_op(KIND_INSERT, 1,   32'sh8000_0000);
        add_op(KIND_INSERT, 3,   -32'sd1);
        add_op(KIND_INSERT, 2,   32'sd0);
        add_op(KIND_INSERT, 127, 32'sd9);
        add_op(KIND_READ,   4,   32'sd0);
        add_op(KIND_READ,   0,   32'sd0);
        add_op(KIND_READ,   5,   32'sd0);
        add_op(KIND_FIND,   0,   -32'sd1);
        add_op(KIND_FIND,   0,   32'sd12345);
        add_op(KIND_DELETE, 0,   32'sd0);
        add_op(KIND_DELETE, 5,   32'sd0);
        add_op(3'd5,        1,   32'sd1);
        add_op(3'd6,        64,  -32'sd1);
        add_op(3'd7,        127, 32'sh5555_aaaa);
        add_op(KIND_DELETE, 2,   32'sd0);
        add_op(KIND_DELETE, 3,   32'sd0);
        add_op(KIND_CLEAR,  0,   32'sd0);
        add_op(KIND_READ,   1,   32'sd0);

        // Random phases: grow, shrink or mixed, with some malformed beats.
        // The first phase is a grow phase that builds the list up.
        first_phase = 1;
        while (pending_ops.size() < TOTAL_ITEMS)
        begin
            if (first_phase)
            begin
                mode = 0;
                phase_len = 75;
                first_phase = 0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                mode = (r < 30) ? 0 : (r < 55) ? 1 : 2;
                phase_len = $urandom_range(10, 60);
                if (r >= 96)
                    add_op(KIND_CLEAR, $urandom_range(0, 127), pick_value());
            end
            for (int i = 0; i < phase_len; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                begin
                    add_op(3'($urandom_range(0, 7)), $urandom_range(0, 127), pick_value());
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    case (mode)
                        0:
                        begin
                            if (r < 70)
                                add_op(KIND_INSERT, pick_pos(stim_len + 1), pick_value());
                            else if (r < 85)
                                add_op(KIND_FIND, $urandom_range(0, 127), pick_search());
                            else
                                add_op(KIND_READ, pick_pos(stim_len), pick_value());
                        end
                        1:
                        begin
                            if (r < 60)
                                add_op(KIND_DELETE, pick_pos(stim_len), pick_value());
                            else if (r < 80)
                                add_op(KIND_READ, pick_pos(stim_len), pick_value());
                            else
                                add_op(KIND_FIND, $urandom_range(0, 127), pick_search());
                        end
                        default:
                        begin
                            if (r < 30)
                                add_op(KIND_INSERT, pick_pos(stim_len + 1), pick_value());
                            else if (r < 55)
                                add_op(KIND_DELETE, pick_pos(stim_len), pick_value());
                            else if (r < 76)
                                add_op(KIND_READ, pick_pos(stim_len), pick_value());
                            else if (r < 98)
                                add_op(KIND_FIND, $urandom_range(0, 127), pick_search());
                            else
                                add_op(KIND_CLEAR, 0, pick_value());
                        end
                    endcase
                end
            end
        end
        n_items = pending_ops.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        wait (n_accepted == n_items);
        wait (n_results >= n_items);
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            n_fail++;
        end

        if (n_fail == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/sle_pkg.sv
sv/sle_cell.sv
sv/sle_group.sv
sv/sequential_list_engine_unit.sv
sv/sle_checker.sv
tb/sv/sequential_list_engine_unit_test.sv
